/* sv/salt_pkg.sv */
// Shared types and character constants for the service attribute list tokenizer.
`default_nettype none

package salt_pkg;

   // Characters the tokenizer recognizes.
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;

   // Token kinds.
   localparam logic [1:0] KIND_KEYWORD = 2'd0;
   localparam logic [1:0] KIND_TAG     = 2'd1;
   localparam logic [1:0] KIND_VALUE   = 2'd2;

   localparam int MaxResults = 4;

   typedef enum logic [1:0] {
      ESC_IDLE,
      ESC_ONE,
      ESC_TWO
   } esc_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic [1:0] token_kind;
      logic       token_end;
      logic       attr_end;
      logic       list_end;
   } result_type;

   // All results that one input word produces, in order.
   typedef struct packed {
      result_type [MaxResults-1:0] res;
      logic [2:0]                  cnt;
   } batch_type;

endpackage

`default_nettype wire

/* sv/salt_core.sv */
// Tokenizer state and the per-word logic that builds a batch of results.
`default_nettype none

module salt_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               fire,
   input  wire logic [7:0]         in_byte,
   input  wire logic               in_last,
   input  wire logic               unquote,
   output salt_pkg::batch_type     batch
);
   import salt_pkg::*;

   typedef struct packed {
      batch_type  b;
      esc_type    phase;
      logic [7:0] first;
      logic       opaque;
   } work_type;

   logic       inside_group_ff, inside_group_in;
   logic       drop_space_ff, drop_space_in;
   logic       space_pending_ff, space_pending_in;
   logic       in_value_ff, in_value_in;
   esc_type    esc_phase_ff, esc_phase_in;
   logic [7:0] esc_first_ff, esc_first_in;
   logic       opaque_ff, opaque_in;
   logic       token_open_ff, token_open_in;

   function automatic batch_type put_res(batch_type b, logic [7:0] d, logic has,
                                         logic [1:0] kind, logic tend, logic aend);
      batch_type r;
      r = b;
      if (r.cnt < 3'(MaxResults)) begin
         r.res[r.cnt[1:0]].out_byte   = d;
         r.res[r.cnt[1:0]].has_byte   = has;
         r.res[r.cnt[1:0]].token_kind = kind;
         r.res[r.cnt[1:0]].token_end  = tend;
         r.res[r.cnt[1:0]].attr_end   = aend;
         r.res[r.cnt[1:0]].list_end   = 1'b0;
         r.cnt = r.cnt + 3'd1;
      end
      return r;
   endfunction

   function automatic logic [3:0] nibble(logic [7:0] c);
      logic is_digit;
      is_digit = (c >= CH_DIGIT_0) && (c <= CH_DIGIT_9);
      // Letters and any other byte both reduce to the low nibble plus nine.
      return is_digit ? c[3:0] : 4'(c[3:0] + 4'd9);
   endfunction

   function automatic work_type plain_byte(work_type w, logic [7:0] c, logic strip,
                                           logic [1:0] kind);
      work_type r;
      r = w;
      if (!(strip && c == CH_QUOTE)) begin
         r.b = put_res(r.b, c, 1'b1, kind, 1'b0, 1'b0);
      end
      return r;
   endfunction

   function automatic work_type decode_byte(work_type w, logic [7:0] c, logic strip,
                                            logic [1:0] kind);
      work_type r;
      r = w;
      if (r.opaque) begin
         r.b = put_res(r.b, c, 1'b1, kind, 1'b0, 1'b0);
      end else if (r.phase == ESC_ONE) begin
         r.first = c;
         r.phase = ESC_TWO;
      end else if (r.phase == ESC_TWO) begin
         r.phase = ESC_IDLE;
         if (r.first == CH_UPPER_F && c == CH_UPPER_F) begin
            r.b = put_res(r.b, CH_BSLASH, 1'b1, kind, 1'b0, 1'b0);
            r.b = put_res(r.b, CH_UPPER_F, 1'b1, kind, 1'b0, 1'b0);
            r.b = put_res(r.b, CH_UPPER_F, 1'b1, kind, 1'b0, 1'b0);
            r.opaque = 1'b1;
         end else begin
            r.b = put_res(r.b, {nibble(r.first), nibble(c)}, 1'b1, kind, 1'b0, 1'b0);
         end
      end else if (c == CH_BSLASH) begin
         r.phase = ESC_ONE;
      end else begin
         r = plain_byte(r, c, strip, kind);
      end
      return r;
   endfunction

   // An escape left open when a token ends is emitted literally.
   function automatic work_type close_token(work_type w, logic strip, logic [1:0] kind,
                                            logic aend);
      work_type r;
      r = w;
      if (r.phase == ESC_ONE) begin
         r.b = put_res(r.b, CH_BSLASH, 1'b1, kind, 1'b0, 1'b0);
      end else if (r.phase == ESC_TWO) begin
         r.b = put_res(r.b, CH_BSLASH, 1'b1, kind, 1'b0, 1'b0);
         r = plain_byte(r, r.first, strip, kind);
      end
      r.phase  = ESC_IDLE;
      r.first  = 8'd0;
      r.opaque = 1'b0;
      r.b = put_res(r.b, 8'd0, 1'b0, kind, 1'b1, aend);
      return r;
   endfunction

   always_comb begin
      work_type   w;
      logic       ws;
      logic [1:0] kind;
      logic [1:0] lidx;

      w.b      = '0;
      w.phase  = esc_phase_ff;
      w.first  = esc_first_ff;
      w.opaque = opaque_ff;
      inside_group_in  = inside_group_ff;
      drop_space_in    = drop_space_ff;
      space_pending_in = space_pending_ff;
      in_value_in      = in_value_ff;
      token_open_in    = token_open_ff;
      ws   = (in_byte == CH_SPACE) || (in_byte == CH_TAB);
      kind = in_value_ff ? KIND_VALUE : KIND_TAG;
      lidx = 2'd0;

      if (!inside_group_ff) begin
         if (ws) begin
            // Whitespace outside groups is dropped.
         end else if (in_byte == CH_LPAREN || in_byte == CH_COMMA) begin
            if (token_open_ff) begin
               w.b = put_res(w.b, 8'd0, 1'b0, KIND_KEYWORD, 1'b1, 1'b1);
            end
            token_open_in = 1'b0;
            if (in_byte == CH_LPAREN) begin
               inside_group_in  = 1'b1;
               in_value_in      = 1'b0;
               drop_space_in    = 1'b1;
               space_pending_in = 1'b0;
               w.phase          = ESC_IDLE;
               w.opaque         = 1'b0;
               token_open_in    = 1'b1;
            end
         end else begin
            w.b = put_res(w.b, in_byte, 1'b1, KIND_KEYWORD, 1'b0, 1'b0);
            token_open_in = 1'b1;
         end
      end else begin
         if (ws) begin
            if (!drop_space_ff) begin
               space_pending_in = 1'b1;
            end
         end else if (in_byte == CH_RPAREN) begin
            w = close_token(w, unquote, kind, 1'b1);
            space_pending_in = 1'b0;
            inside_group_in  = 1'b0;
            in_value_in      = 1'b0;
            token_open_in    = 1'b0;
            drop_space_in    = 1'b1;
         end else if ((in_byte == CH_EQUAL && !in_value_ff) ||
                      (in_byte == CH_COMMA && in_value_ff)) begin
            w = close_token(w, unquote, kind, 1'b0);
            space_pending_in = 1'b0;
            in_value_in      = 1'b1;
            drop_space_in    = 1'b1;
            token_open_in    = 1'b1;
         end else if (in_byte == CH_EQUAL || in_byte == CH_COMMA) begin
            space_pending_in = 1'b0;
            drop_space_in    = 1'b1;
            w = decode_byte(w, in_byte, unquote, kind);
         end else begin
            if (space_pending_ff) begin
               w = decode_byte(w, CH_SPACE, unquote, kind);
            end
            space_pending_in = 1'b0;
            drop_space_in    = 1'b0;
            w = decode_byte(w, in_byte, unquote, kind);
         end
      end

      if (in_last) begin
         if (inside_group_in) begin
            w = close_token(w, unquote, in_value_in ? KIND_VALUE : KIND_TAG, 1'b1);
         end else if (token_open_in) begin
            w.b = put_res(w.b, 8'd0, 1'b0, KIND_KEYWORD, 1'b1, 1'b1);
         end
         if (w.b.cnt == 3'd0) begin
            w.b = put_res(w.b, 8'd0, 1'b0, KIND_KEYWORD, 1'b0, 1'b0);
         end
         lidx = 2'(w.b.cnt - 3'd1);
         w.b.res[lidx].list_end = 1'b1;
         inside_group_in  = 1'b0;
         drop_space_in    = 1'b1;
         space_pending_in = 1'b0;
         in_value_in      = 1'b0;
         w.phase          = ESC_IDLE;
         w.first          = 8'd0;
         w.opaque         = 1'b0;
         token_open_in    = 1'b0;
      end

      esc_phase_in = w.phase;
      esc_first_in = w.first;
      opaque_in    = w.opaque;
      batch        = w.b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inside_group_ff  <= 1'b0;
         drop_space_ff    <= 1'b1;
         space_pending_ff <= 1'b0;
         in_value_ff      <= 1'b0;
         esc_phase_ff     <= ESC_IDLE;
         esc_first_ff     <= 8'd0;
         opaque_ff        <= 1'b0;
         token_open_ff    <= 1'b0;
      end else if (fire) begin
         inside_group_ff  <= inside_group_in;
         drop_space_ff    <= drop_space_in;
         space_pending_ff <= space_pending_in;
         in_value_ff      <= in_value_in;
         esc_phase_ff     <= esc_phase_in;
         esc_first_ff     <= esc_first_in;
         opaque_ff        <= opaque_in;
         token_open_ff    <= token_open_in;
      end
   end

endmodule

`default_nettype wire

/* sv/salt_rsp_buf.sv */
// Result register that holds one batch and hands its results out one word at a time.
`default_nettype none

module salt_rsp_buf (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                load,
   input  wire salt_pkg::batch_type batch,
   output logic                     free,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output salt_pkg::result_type     head
);
   import salt_pkg::*;

   result_type [MaxResults-1:0] res_ff;
   logic [2:0]                  rem_ff;
   logic [1:0]                  idx_ff;
   logic                        take;

   assign rsp_valid = (rem_ff != 3'd0);
   assign take      = rsp_valid && rsp_ready;
   // A new batch may land when the last word of the current one leaves.
   assign free      = (rem_ff == 3'd0) || (rem_ff == 3'd1 && rsp_ready);
   assign head      = res_ff[idx_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         rem_ff <= 3'd0;
         idx_ff <= 2'd0;
      end else if (load) begin
         rem_ff <= batch.cnt;
         idx_ff <= 2'd0;
      end else if (take) begin
         rem_ff <= rem_ff - 3'd1;
         idx_ff <= idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         res_ff <= batch.res;
      end
   end

endmodule

`default_nettype wire

/* sv/service_attribute_list_tokenizer.sv */
// Top level of the service attribute list tokenizer.
//
//   Port group   Direction  Handshake            Contents
//   req_         in         req_valid/req_ready  one list character and its last flag
//   rsp_         out        rsp_valid/rsp_ready  one token byte or marker with end flags
//   csr_         in         csr_wr_en            quote removal bit
//
// A character is held in the input register, then its results (zero to four
// words) are built combinationally and loaded into the result register.
// Throughput is one character per cycle while each yields at most one word
// and rsp_ready is high; more words hold the input until the last one leaves.
// Reset is synchronous and returns the parser to the start of a list.
// A stall on rsp_ready backs up into req_ready through the result register.
`default_nettype none

module service_attribute_list_tokenizer (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_in_byte,
   input  wire logic       req_in_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_has_byte,
   output logic [1:0]      rsp_token_kind,
   output logic            rsp_token_end,
   output logic            rsp_attr_end,
   output logic            rsp_list_end,
   input  wire logic       csr_wr_en,
   input  wire logic       csr_wr_data
);
   import salt_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;
   logic       unquote_ff;
   logic       fire;
   logic       buf_free;
   batch_type  batch;
   result_type head;

   assign fire      = in_valid_ff && buf_free;
   assign req_ready = !in_valid_ff || fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_last_ff <= req_in_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unquote_ff <= 1'b0;
      end else if (csr_wr_en) begin
         unquote_ff <= csr_wr_data;
      end
   end

   salt_core u_core (
      .clock        (clock),
      .reset        (reset),
      .fire         (fire),
      .in_byte      (in_byte_ff),
      .in_last      (in_last_ff),
      .unquote      (unquote_ff),
      .batch        (batch)
   );

   salt_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .load      (fire),
      .batch     (batch),
      .free      (buf_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   assign rsp_out_byte   = head.out_byte;
   assign rsp_has_byte   = head.has_byte;
   assign rsp_token_kind = head.token_kind;
   assign rsp_token_end  = head.token_end;
   assign rsp_attr_end   = head.attr_end;
   assign rsp_list_end   = head.list_end;

endmodule

`default_nettype wire
